// ===== sv/bdlr_pkg.sv =====
// Shared types and constants for the button debounce, long-press and repeat block.
package bdlr_pkg;

   localparam int FIELD_W     = 6;
   localparam int TIME_W      = 32;
   localparam int DEBOUNCE_W  = 8;
   localparam int HOLD_W      = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE        = 3'd0,
      CSR_LONG_PRESS      = 3'd1,
      CSR_REPEAT_START    = 3'd2,
      CSR_REPEAT_INTERVAL = 3'd3,
      CSR_REPEAT_ENABLE   = 3'd4
   } csr_index_type;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET        = 8'd20;
   localparam logic [HOLD_W-1:0]     LONG_PRESS_RESET      = 16'd1000;
   localparam logic [HOLD_W-1:0]     REPEAT_START_RESET    = 16'd400;
   localparam logic [HOLD_W-1:0]     REPEAT_INTERVAL_RESET = 16'd150;
   localparam logic [FIELD_W-1:0]    REPEAT_ENABLE_RESET   = 6'd24;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ms;
      logic [HOLD_W-1:0]     long_hold;
      logic [HOLD_W-1:0]     repeat_delay;
      logic [HOLD_W-1:0]     repeat_period;
   } timing_cfg_type;

   typedef struct packed {
      logic fire;
      logic long_hit;
      logic held;
   } lane_result_type;

endpackage

// ===== sv/bdlr_lane.sv =====
// Per-button debounce, long-press and repeat tracker.
module bdlr_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     raw_level,
   input  logic [31:0]              time_ms,
   input  bdlr_pkg::timing_cfg_type cfg,
   input  logic                     repeat_en,
   output bdlr_pkg::lane_result_type result
);
   import bdlr_pkg::*;

   logic              cand_ff,     cand_in;
   logic [TIME_W-1:0] changed_ff,  changed_in;
   logic              pressed_ff,  pressed_in;
   logic [TIME_W-1:0] press_ff,    press_in;
   logic [TIME_W-1:0] lastrep_ff,  lastrep_in;
   logic              longf_ff,    longf_in;

   logic [TIME_W-1:0] stable_age;
   logic [TIME_W-1:0] hold_age;
   logic [TIME_W-1:0] repeat_age;
   logic              stable;
   logic              long_due;
   logic              repeat_due;

   always_comb begin
      cand_in    = raw_level;
      changed_in = (raw_level != cand_ff) ? time_ms : changed_ff;
      stable_age = time_ms - changed_in;
      hold_age   = time_ms - press_ff;
      repeat_age = time_ms - lastrep_ff;
      stable     = stable_age >= {{(TIME_W-DEBOUNCE_W){1'b0}}, cfg.debounce_ms};
      long_due   = !longf_ff && (hold_age >= {{(TIME_W-HOLD_W){1'b0}}, cfg.long_hold});
      repeat_due = repeat_en
                   && (hold_age >= {{(TIME_W-HOLD_W){1'b0}}, cfg.repeat_delay})
                   && (repeat_age >= {{(TIME_W-HOLD_W){1'b0}}, cfg.repeat_period});

      pressed_in      = pressed_ff;
      press_in        = press_ff;
      lastrep_in      = lastrep_ff;
      longf_in        = longf_ff;
      result.fire     = 1'b0;
      result.long_hit = 1'b0;

      if (stable) begin
         if (!cand_in && !pressed_ff) begin
            // record the press; hold checks start on the next poll
            pressed_in = 1'b1;
            press_in   = time_ms;
            lastrep_in = time_ms;
            longf_in   = 1'b0;
         end else if (cand_in && pressed_ff) begin
            pressed_in  = 1'b0;
            result.fire = !longf_ff;
         end else if (pressed_ff) begin
            if (long_due) begin
               longf_in        = 1'b1;
               result.long_hit = 1'b1;
            end
            if (repeat_due) begin
               lastrep_in  = time_ms;
               result.fire = 1'b1;
            end
         end
      end
      result.held = pressed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff    <= 1'b1;
         changed_ff <= '0;
         pressed_ff <= 1'b0;
         press_ff   <= '0;
         lastrep_ff <= '0;
         longf_ff   <= 1'b0;
      end else if (step) begin
         cand_ff    <= cand_in;
         changed_ff <= changed_in;
         pressed_ff <= pressed_in;
         press_ff   <= press_in;
         lastrep_ff <= lastrep_in;
         longf_ff   <= longf_in;
      end
   end

endmodule

// ===== sv/bdlr_merge.sv =====
// Merge of per-button results into masks, with the response register.
module bdlr_merge #(
   parameter int BUTTON_COUNT = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  bdlr_pkg::lane_result_type lanes [BUTTON_COUNT],
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [bdlr_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bdlr_pkg::*;

   logic [FIELD_W-1:0] fire_mask, long_mask, held_mask;
   logic               valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] data_ff;

   for (genvar i = 0; i < FIELD_W; i++) begin : g_bit
      if (i < BUTTON_COUNT) begin : g_lane
         assign fire_mask[i] = lanes[i].fire;
         assign long_mask[i] = lanes[i].long_hit;
         assign held_mask[i] = lanes[i].held;
      end else begin : g_none
         assign fire_mask[i] = 1'b0;
         assign long_mask[i] = 1'b0;
         assign held_mask[i] = 1'b0;
      end
   end

   // hold while stalled, load on every accepted request
   assign valid_in = step || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         data_ff <= {{(RSP_DATA_W-3*FIELD_W){1'b0}}, held_mask, long_mask, fire_mask};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== sv/button_debounce_longpress_repeat.sv =====
// Top level of the button debounce, long-press and auto-repeat block.
//
// Usage:
//   Each request on req_ carries one poll: the raw active-low button levels
//   and the current millisecond time. Every request yields exactly one
//   response on rsp_ with the fire, long-press and held masks of that poll.
//   Each button has its own tracker lane; all lanes update in the same cycle
//   and the merge stage packs their results into the response register.
//   The response is registered and is valid in the cycle after the request is accepted.
//   Throughput: one request per cycle while the response is not stalled, set by
//   the combinational lane update (three 32-bit time differences and four compares per lane).
//   Stall: the response register holds while rsp_tready is low; a new
//   request is taken in the cycle the pending response leaves, so
//   req_tready = !rsp_tvalid || rsp_tready.
//   Reset: lanes return to released with zero timestamps, registers return
//   to their defaults (20, 1000, 400, 150, 0x18); no clearing pass.
//   Configuration: csr_we writes csr_wdata into the register at csr_index in
//   the same edge; unknown indexes are dropped. Write only while idle.
module button_debounce_longpress_repeat #(
   parameter int BUTTON_COUNT = 6
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: button_levels[5:0], time_ms[37:6], zero pad [39:38]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [bdlr_pkg::REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: fire_mask[5:0], long_mask[11:6], held_mask[17:12], zero pad [23:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [bdlr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [bdlr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bdlr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bdlr_pkg::*;

   timing_cfg_type     cfg_ff;
   logic [FIELD_W-1:0] repeat_mask_ff;

   logic               step;
   logic [FIELD_W-1:0] levels;
   logic [TIME_W-1:0]  now;
   lane_result_type    lane_res [BUTTON_COUNT];

   assign req_tready = !rsp_tvalid || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign levels     = req_tdata[FIELD_W-1:0];
   assign now        = req_tdata[FIELD_W +: TIME_W];

   // register file; writes to unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.long_hold     <= LONG_PRESS_RESET;
         cfg_ff.repeat_delay  <= REPEAT_START_RESET;
         cfg_ff.repeat_period <= REPEAT_INTERVAL_RESET;
         repeat_mask_ff       <= REPEAT_ENABLE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE:        cfg_ff.debounce_ms   <= csr_wdata[DEBOUNCE_W-1:0];
            CSR_LONG_PRESS:      cfg_ff.long_hold     <= csr_wdata[HOLD_W-1:0];
            CSR_REPEAT_START:    cfg_ff.repeat_delay  <= csr_wdata[HOLD_W-1:0];
            CSR_REPEAT_INTERVAL: cfg_ff.repeat_period <= csr_wdata[HOLD_W-1:0];
            CSR_REPEAT_ENABLE:   repeat_mask_ff       <= csr_wdata[FIELD_W-1:0];
            default: ;
         endcase
      end
   end

   // one lane per button; buttons past the field width read as pressed
   // with repeat disabled, and never reach the masks
   for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
      logic raw_bit;
      logic rep_bit;
      if (i < FIELD_W) begin : g_in
         assign raw_bit = levels[i];
         assign rep_bit = repeat_mask_ff[i];
      end else begin : g_out
         assign raw_bit = 1'b0;
         assign rep_bit = 1'b0;
      end

      bdlr_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .step      (step),
         .raw_level (raw_bit),
         .time_ms   (now),
         .cfg       (cfg_ff),
         .repeat_en (rep_bit),
         .result    (lane_res[i])
      );
   end

   bdlr_merge #(
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .lanes      (lane_res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== sv/bdlr_checker.sv =====
// Port-level checks for the button debounce block, bound to its top level.
module bdlr_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [bdlr_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bdlr_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted request produced no response");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while response stalled");

   a_long_implies_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[2*FIELD_W-1:FIELD_W]
                       & ~rsp_tdata[3*FIELD_W-1:2*FIELD_W]) == '0))
      else $error("long press reported for a button not held");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind button_debounce_longpress_repeat bdlr_checker u_bdlr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
